>>> src/ptld_pkg.sv
// Shared constants and types of the point-to-line distance pipeline.
package ptld_pkg;

  localparam int COORD_W         = 24;
  localparam int NUM_AXES        = 3;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int DOT_W           = PROD_W + 2;
  localparam int LEN_W           = PROD_W;
  localparam int MAG_W           = DOT_W - 1;
  localparam int T_FRAC          = 24;
  localparam int Q_W             = 50;
  localparam int HALF_W          = Q_W / 2;
  localparam int SCALE_W         = DIFF_W + Q_W;
  localparam int E_W             = 29;
  localparam int SQ_W            = 2 * E_W;
  localparam int SSUM_W          = SQ_W + 2;
  localparam int SQRT_ITERATIONS = 25;
  localparam int RAD_W           = 2 * SQRT_ITERATIONS;
  localparam int DIST_W          = 25;
  localparam int MODE_W          = 2;
  localparam int IN_TDATA_W      = ((9 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W     = ((DIST_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINE    = 2'd0,
    MODE_RAY     = 2'd1,
    MODE_SEGMENT = 2'd2
  } line_mode_e;

  typedef struct packed {
    logic [NUM_AXES-1:0][DIFF_W-1:0] w;
    logic [NUM_AXES-1:0][DIFF_W-1:0] d;
    logic [MODE_W-1:0]               mode;
    logic                            neg;
    logic                            degen;
  } ctx_t;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [Q_W-1:0]   rest;
    logic [Q_W-1:0]   quo;
    logic [LEN_W-1:0] len2;
    ctx_t             ctx;
  } div_t;

  typedef struct packed {
    logic [RAD_W-1:0]           rem;
    logic [SQRT_ITERATIONS-1:0] root;
    logic                       degen;
  } sqrt_t;

endpackage

>>> src/point_to_line_distance.sv
// Pipelined distance from a 3D point to a line, ray or segment.
//
//  Channel  Dir  tdata (low bit up)                                   tuser
//  s_axis   in   point_x,y,z, start_x,y,z, end_x,y,z (24b each)       line_mode
//  m_axis   out  distance (25b), zero fill to 32b                     degenerate
//
// One item enters per cycle while the output is not stalled; the pipeline holds the 50 steps of the
// pipelined divider for t and the 25 steps of the pipelined square root.
// Reset clears only the stage valid bits; no state is kept between items.
// A stalled output holds every stage, so nothing is lost or repeated.
module point_to_line_distance (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [ptld_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // line_mode
  input  logic [ptld_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // distance
  output logic [ptld_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0]                       m_axis_tuser
);
  import ptld_pkg::*;

  logic ce;

  logic                          a_v_q;
  ctx_t                          a_q, a_d;
  logic                          b_v_q;
  ctx_t                          b_ctx_q;
  logic signed [PROD_W-1:0]      wd_q [NUM_AXES];
  logic signed [PROD_W-1:0]      dd_q [NUM_AXES];
  logic                          div_v_q [Q_W+1];
  div_t                          div_q [Q_W+1];
  div_t                          div_d;
  logic                          t_v_q;
  ctx_t                          t_ctx_q;
  logic [Q_W-1:0]                tmag_q, tmag_d;
  logic                          tneg_q, tneg_d;
  logic [DIFF_W-1:0]             dmag [NUM_AXES];
  logic                          m1_v_q;
  ctx_t                          m1_ctx_q;
  logic [PROD_W-1:0]             plo_q [NUM_AXES];
  logic [PROD_W-1:0]             phi_q [NUM_AXES];
  logic [NUM_AXES-1:0]           psign_q;
  logic                          m2_v_q;
  logic                          m2_degen_q;
  logic signed [E_W-1:0]         e_q [NUM_AXES];
  logic signed [E_W-1:0]         e_d [NUM_AXES];
  logic                          m3_v_q;
  logic                          m3_degen_q;
  logic [SQ_W-1:0]               sq_q [NUM_AXES];
  logic                          sq_v_q [SQRT_ITERATIONS+1];
  sqrt_t                         sq_st_q [SQRT_ITERATIONS+1];
  sqrt_t                         sq_st_d;

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // Differences W = P - S and D = E - S.
  always_comb begin
    a_d = '0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      a_d.w[ax] = DIFF_W'($signed(s_axis_tdata[ax*COORD_W +: COORD_W]))
                - DIFF_W'($signed(s_axis_tdata[(NUM_AXES+ax)*COORD_W +: COORD_W]));
      a_d.d[ax] = DIFF_W'($signed(s_axis_tdata[(2*NUM_AXES+ax)*COORD_W +: COORD_W]))
                - DIFF_W'($signed(s_axis_tdata[(NUM_AXES+ax)*COORD_W +: COORD_W]));
    end
    a_d.mode = s_axis_tuser;
  end

  // Dot product, squared length and divider setup.
  always_comb begin
    logic signed [DOT_W-1:0] dot;
    logic [LEN_W-1:0]        len2;
    logic [MAG_W-1:0]        mag;
    dot  = '0;
    len2 = '0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      dot  = dot + DOT_W'(wd_q[ax]);
      len2 = len2 + LEN_W'(dd_q[ax]);
    end
    mag             = dot[DOT_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
    div_d.ctx       = b_ctx_q;
    div_d.ctx.neg   = dot[DOT_W-1];
    div_d.ctx.degen = (len2 == '0);
    div_d.len2      = len2;
    div_d.quo       = '0;
    div_d.rem       = LEN_W'(mag >> (Q_W - T_FRAC));
    div_d.rest      = Q_W'({mag, {T_FRAC{1'b0}}});
  end

  // Sign, clamping and the degenerate case applied to t.
  always_comb begin
    logic [Q_W-1:0] q;
    logic           neg;
    q      = div_q[Q_W].quo;
    neg    = div_q[Q_W].ctx.neg;
    tmag_d = q;
    tneg_d = neg;
    if (div_q[Q_W].ctx.degen) begin
      tmag_d = '0;
      tneg_d = 1'b0;
    end else if (neg && (div_q[Q_W].ctx.mode != MODE_LINE)) begin
      tmag_d = '0;
      tneg_d = 1'b0;
    end else if (!neg && (div_q[Q_W].ctx.mode >= MODE_SEGMENT)
                 && (q > (Q_W'(1) << T_FRAC))) begin
      tmag_d = Q_W'(1) << T_FRAC;
    end
  end

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      dmag[ax] = t_ctx_q.d[ax][DIFF_W-1] ? -t_ctx_q.d[ax] : t_ctx_q.d[ax];
    end
  end

  // Rounded offset D*t and the remaining component of P - N.
  always_comb begin
    logic [SCALE_W-1:0] full;
    logic [E_W-1:0]     m;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      full    = {phi_q[ax], {HALF_W{1'b0}}} + SCALE_W'(plo_q[ax]);
      full    = full + (SCALE_W'(1) << (T_FRAC - 1));
      m       = E_W'(full >> T_FRAC);
      e_d[ax] = E_W'($signed(m1_ctx_q.w[ax]))
              - (psign_q[ax] ? $signed(-m) : $signed(m));
    end
  end

  // Squared distance, saturated to the root range.
  always_comb begin
    logic [SSUM_W-1:0] s;
    s = '0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      s = s + SSUM_W'(sq_q[ax]);
    end
    sq_st_d.rem   = (s[SSUM_W-1:RAD_W] != '0) ? '1 : s[RAD_W-1:0];
    sq_st_d.root  = '0;
    sq_st_d.degen = m3_degen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      div_v_q[0] <= 1'b0;
      t_v_q      <= 1'b0;
      m1_v_q     <= 1'b0;
      m2_v_q     <= 1'b0;
      m3_v_q     <= 1'b0;
      sq_v_q[0]  <= 1'b0;
    end else if (ce) begin
      a_v_q      <= s_axis_tvalid;
      b_v_q      <= a_v_q;
      div_v_q[0] <= b_v_q;
      t_v_q      <= div_v_q[Q_W];
      m1_v_q     <= t_v_q;
      m2_v_q     <= m1_v_q;
      m3_v_q     <= m2_v_q;
      sq_v_q[0]  <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      a_q        <= a_d;
      b_ctx_q    <= a_q;
      div_q[0]   <= div_d;
      t_ctx_q    <= div_q[Q_W].ctx;
      tmag_q     <= tmag_d;
      tneg_q     <= tneg_d;
      m1_ctx_q   <= t_ctx_q;
      m2_degen_q <= m1_ctx_q.degen;
      m3_degen_q <= m2_degen_q;
      sq_st_q[0] <= sq_st_d;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        wd_q[ax]    <= PROD_W'($signed(a_q.w[ax])) * PROD_W'($signed(a_q.d[ax]));
        dd_q[ax]    <= PROD_W'($signed(a_q.d[ax])) * PROD_W'($signed(a_q.d[ax]));
        plo_q[ax]   <= PROD_W'(dmag[ax]) * PROD_W'(tmag_q[HALF_W-1:0]);
        phi_q[ax]   <= PROD_W'(dmag[ax]) * PROD_W'(tmag_q[Q_W-1:HALF_W]);
        psign_q[ax] <= t_ctx_q.d[ax][DIFF_W-1] ^ tneg_q;
        e_q[ax]     <= e_d[ax];
        sq_q[ax]    <= SQ_W'(e_q[ax]) * SQ_W'(e_q[ax]);
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    div_t                step_d;
    logic [LEN_W:0]      shifted;
    logic                ge;

    always_comb begin
      shifted       = {div_q[k].rem, div_q[k].rest[Q_W-1]};
      ge            = shifted >= {1'b0, div_q[k].len2};
      step_d        = div_q[k];
      step_d.rem    = ge ? LEN_W'(shifted - {1'b0, div_q[k].len2}) : LEN_W'(shifted);
      step_d.rest   = div_q[k].rest << 1;
      step_d.quo    = {div_q[k].quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k+1] <= 1'b0;
      end else if (ce) begin
        div_v_q[k+1] <= div_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        div_q[k+1] <= step_d;
      end
    end
  end

  for (genvar k = 0; k < SQRT_ITERATIONS; k++) begin : g_sqrt
    localparam int BIT = SQRT_ITERATIONS - 1 - k;
    sqrt_t          step_d;
    logic [RAD_W:0] trial;
    logic           ge;

    always_comb begin
      trial  = ((RAD_W+1)'(sq_st_q[k].root) << (BIT + 1)) + ((RAD_W+1)'(1) << (2 * BIT));
      ge     = {1'b0, sq_st_q[k].rem} >= trial;
      step_d = sq_st_q[k];
      if (ge) begin
        step_d.rem  = RAD_W'({1'b0, sq_st_q[k].rem} - trial);
        step_d.root = sq_st_q[k].root | (SQRT_ITERATIONS'(1) << BIT);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (ce) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        sq_st_q[k+1] <= step_d;
      end
    end
  end

  assign m_axis_tvalid   = sq_v_q[SQRT_ITERATIONS];
  assign m_axis_tdata    = OUT_TDATA_W'(sq_st_q[SQRT_ITERATIONS].root);
  assign m_axis_tuser[0] = sq_st_q[SQRT_ITERATIONS].degen;

endmodule

>>> src/ptld_checker.sv
// Port-level assertions for the point-to-line distance block, bound to its top level.
module ptld_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ptld_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                       m_axis_tuser
);
  import ptld_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Output item changed while stalled.");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("Input taken while the pipeline is stalled.");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:DIST_W] == '0))
    else $error("Distance fill bits are not zero.");

endmodule

bind point_to_line_distance ptld_checker u_ptld_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench of the point-to-line distance pipeline.
`timescale 1ns / 100ps

module testbench;
  import ptld_pkg::*;

  localparam int LATENCY = 83;

  typedef struct {
    logic [IN_TDATA_W-1:0] coords;
    logic [MODE_W-1:0]     mode;
  } query_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              degenerate;
  } dist_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  query_t pending_queries[$];
  dist_t  expected_dists[$];
  int     error_count = 0;
  int     hold_cycles = 0;
  bit     feeding_done = 1'b0;
  bit     pause_sender = 1'b0;
  int     send_gap = 0;
  int     recv_gap = 0;

  point_to_line_distance dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint coord_at(logic [IN_TDATA_W-1:0] c, int idx);
    logic signed [COORD_W-1:0] v;
    v = c[idx*COORD_W +: COORD_W];
    return longint'(v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic dist_t nearest_distance(query_t q);
    longint w[3], d[3];
    longint dot, t, prod, err;
    longint unsigned len2, sq_sum, quo, rem, rnd, root, cand;
    logic [127:0] wide;
    dist_t r;
    dot = 0; len2 = 0; sq_sum = 0; t = 0;
    for (int i = 0; i < 3; i++) begin
      w[i] = coord_at(q.coords, i) - coord_at(q.coords, 3 + i);
      d[i] = coord_at(q.coords, 6 + i) - coord_at(q.coords, 3 + i);
      dot += w[i] * d[i];
      len2 += d[i] * d[i];
    end
    r.degenerate = (len2 == 0);
    if (!r.degenerate) begin
      quo = magnitude(dot) / len2;
      rem = magnitude(dot) % len2;
      for (int i = 0; i < T_FRAC; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= len2) begin
          rem -= len2;
          quo |= 1;
        end
      end
      t = dot < 0 ? -longint'(quo) : longint'(quo);
      if (q.mode != MODE_LINE && t < 0) t = 0;
      if (q.mode >= MODE_SEGMENT && t > (longint'(1) << T_FRAC)) t = longint'(1) << T_FRAC;
    end
    for (int i = 0; i < 3; i++) begin
      prod = d[i] * t;
      rnd = (magnitude(prod) + (64'd1 << (T_FRAC - 1))) >> T_FRAC;
      err = w[i] - (prod < 0 ? -longint'(rnd) : longint'(rnd));
      sq_sum += err * err;
    end
    root = 0;
    for (int i = SQRT_ITERATIONS - 1; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      wide = 128'(cand) * 128'(cand);
      if (wide <= 128'(sq_sum)) root = cand;
    end
    r.distance = root > 64'h1FFFFFF ? 25'h1FFFFFF : root[DIST_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int kind);
    case (kind)
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(8191)) - 24'd4096;
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return COORD_W'($urandom_range(262143)) - 24'd131072;
    endcase
  endfunction

  task automatic add_query(logic [COORD_W-1:0] c[9], logic [MODE_W-1:0] m);
    query_t q;
    for (int i = 0; i < 9; i++) q.coords[i*COORD_W +: COORD_W] = c[i];
    q.mode = m;
    pending_queries.push_back(q);
  endtask

  // Driver: one item offered per cycle unless a gap, a pause or a stalled input is in force.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dists.push_back(nearest_distance('{s_axis_tdata, s_axis_tuser}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!pause_sender && pending_queries.size() > 0) begin
          query_t q;
          q = pending_queries.pop_front();
          s_axis_tdata <= q.coords;
          s_axis_tuser <= q.mode;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(3) == 0) begin
            send_gap <= ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each item against the oldest expected distance and degenerate flag, and checks its fill bits.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dists.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata, 0);
        end else begin
          dist_t e;
          e = expected_dists.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== e.distance)
            report_mismatch("distance", m_axis_tdata[DIST_W-1:0], e.distance);
          if (m_axis_tuser[0] !== e.degenerate)
            report_mismatch("degenerate", m_axis_tuser[0], e.degenerate);
          if (m_axis_tdata[OUT_TDATA_W-1:DIST_W] !== '0)
            report_mismatch("fill bits", m_axis_tdata[OUT_TDATA_W-1:DIST_W], 0);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(4) == 0) begin
          recv_gap <= ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
        end
      end
    end
  end

  initial begin
    logic [COORD_W-1:0] c[9];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, all modes, degenerate line, t below 0 and above 1.
    for (int m = 0; m < 4; m++) begin
      c = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
            24'h800000, 24'h800000, 24'h800000};
      add_query(c, MODE_W'(m));
      c = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
            24'h800000, 24'h7FFFFF, 24'h800000};
      add_query(c, MODE_W'(m));
      c = '{24'h001000, 24'h002000, 0, 0, 0, 0, 24'h001000, 0, 0};
      add_query(c, MODE_W'(m));
      c = '{24'hFFF000, 24'h001000, 0, 0, 0, 0, 24'h001000, 0, 0};
      add_query(c, MODE_W'(m));
      c = '{24'h003000, 24'hFFF000, 24'h000800, 0, 0, 0, 24'h001000, 0, 0};
      add_query(c, MODE_W'(m));
      c = '{24'h123456, 24'hABCDEF, 0, 24'h000100, 24'h000100, 0,
            24'h000100, 24'h000100, 0};
      add_query(c, MODE_W'(m));
    end
    wait (pending_queries.size() == 0 && expected_dists.size() == 0);
    // The sender keeps offering while the receiver holds off for a long stretch.
    hold_cycles = 300;
    for (int n = 0; n < 500; n++) begin
      int kind;
      kind = $urandom_range(3);
      for (int i = 0; i < 9; i++) c[i] = rand_coord(kind);
      if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
      if ($urandom_range(5) == 0) begin
        c[2] = 0; c[5] = 0; c[8] = 0;
      end
      add_query(c, MODE_W'($urandom_range(3)));
      if (n == 250) begin
        wait (pending_queries.size() == 0);
        pause_sender = 1'b1;
        wait (expected_dists.size() == 0 && !s_axis_tvalid);
        pause_sender = 1'b0;
      end
    end
    feeding_done = 1'b1;
  end

  initial begin
    wait (feeding_done && pending_queries.size() == 0 && !s_axis_tvalid
          && expected_dists.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
